[hw/rtl/rcwp_pkg.sv]
// Package with the frame geometry and derived widths for the row crop word packer.
`timescale 1ns / 1ps

package rcwp_pkg;

    localparam int IMAGE_WIDTH     = 640;
    localparam int IMAGE_HEIGHT    = 480;
    localparam int BORDER          = 2;

    localparam int PAD_WIDTH       = IMAGE_WIDTH + 2 * BORDER;
    localparam int PAD_HEIGHT      = IMAGE_HEIGHT + 2 * BORDER;
    localparam int PIXELS_PER_WORD = 16;
    localparam int WORDS_PER_ROW   = IMAGE_WIDTH / PIXELS_PER_WORD;

    localparam int PIXEL_W         = 8;
    localparam int HALF_W          = 64;
    localparam int WORD_W          = 2 * HALF_W;
    localparam int HEADER_ROW_W    = 16;
    localparam int COL_W           = $clog2(PAD_WIDTH);
    localparam int ROW_W           = $clog2(PAD_HEIGHT);
    localparam int BYTE_CNT_W      = $clog2(PIXELS_PER_WORD);
    localparam int WORD_CNT_W      = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;

endpackage

[hw/rtl/rcwp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module rcwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/row_crop_word_packer_core.sv]
// Top level of the row crop word packer: row store, byte-serial word assembly and output register.
//
// The pixel channel takes one 8-bit pixel of the border-padded frame per request, in
// raster order, and writes it into a one-row store at its column. Pixels are taken one
// per cycle while pixel_stall is low. On the last pixel of a row that is not a top or
// bottom border row, the block sends a packet of 1 + IMAGE_WIDTH/16 requests on the
// word channel: a header carrying the cropped row number, then the data words of 16
// centre pixels each. The header appears in the cycle after that pixel is taken. Each
// data word is built by reading the row store one byte per cycle into a shift
// register: 16 reads, the registered read of the row store, then the load of the
// output register. pixel_stall stays high from the header until the last data word
// of a packet is loaded into the output register.
// An output register separates the two channels; while word_stall holds a word, the
// load of the next word waits, and the last pixel of a row is refused only while
// the output register is full and stalled.
// Reset clears the column and row counters, the control state and the output valid.
// The row store is not cleared; every entry that a packet reads is written earlier in
// the same row.
`timescale 1ns / 1ps

module row_crop_word_packer_core
    import rcwp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  logic [PIXEL_W-1:0] pixel,
    output logic               word_valid,
    input  logic               word_stall,
    output logic [HALF_W-1:0]  word_low,
    output logic [HALF_W-1:0]  word_high,
    output logic               frame_start,
    output logic               packet_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    state_t                  state_reg, state_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [COL_W-1:0]        rd_addr_reg, rd_addr_next;
    logic [BYTE_CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic [WORD_CNT_W-1:0]   word_cnt_reg, word_cnt_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [WORD_W-1:0]       shift_reg, shift_next;
    logic                    out_valid_reg, out_valid_next;
    logic [HALF_W-1:0]       word_low_reg, word_low_next;
    logic [HALF_W-1:0]       word_high_reg, word_high_next;
    logic                    frame_start_reg, frame_start_next;
    logic                    packet_last_reg, packet_last_next;

    logic                    col_last;
    logic                    row_last;
    logic                    row_kept;
    logic                    out_free;
    logic                    pixel_take;
    logic                    rd_en;
    logic [PIXEL_W-1:0]      rd_data;
    logic [ROW_W-1:0]        crop_row;

    rcwp_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (PAD_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (pixel_take),
        .wr_addr (col_reg),
        .wr_data (pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    assign col_last    = (col_reg == COL_W'(PAD_WIDTH - 1));
    assign row_last    = (row_reg == ROW_W'(PAD_HEIGHT - 1));
    assign row_kept    = (row_reg >= ROW_W'(BORDER)) && (row_reg < ROW_W'(PAD_HEIGHT - BORDER));
    assign crop_row    = row_reg - ROW_W'(BORDER);
    assign out_free    = !out_valid_reg || !word_stall;
    assign pixel_stall = (state_reg != S_IDLE) || (col_last && !out_free);
    assign pixel_take  = pixel_valid && !pixel_stall;

    always_comb
    begin
        state_next       = state_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        rd_addr_next     = rd_addr_reg;
        issue_cnt_next   = issue_cnt_reg;
        word_cnt_next    = word_cnt_reg;
        out_valid_next   = out_valid_reg;
        word_low_next    = word_low_reg;
        word_high_next   = word_high_reg;
        frame_start_next = frame_start_reg;
        packet_last_next = packet_last_reg;
        rd_en            = 1'b0;

        if (out_valid_reg && !word_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pixel_take)
                begin
                    if (col_last)
                    begin
                        col_next = '0;
                        row_next = row_last ? '0 : row_reg + ROW_W'(1);
                        if (row_kept)
                        begin
                            out_valid_next   = 1'b1;
                            word_low_next    = {{(HALF_W - HEADER_ROW_W){1'b0}},
                                                HEADER_ROW_W'(crop_row)};
                            word_high_next   = '0;
                            frame_start_next = (row_reg == ROW_W'(BORDER));
                            packet_last_next = 1'b0;
                            rd_addr_next     = COL_W'(BORDER);
                            issue_cnt_next   = '0;
                            word_cnt_next    = '0;
                            state_next       = S_READ;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            S_READ:
            begin
                rd_en          = 1'b1;
                rd_addr_next   = rd_addr_reg + COL_W'(1);
                issue_cnt_next = issue_cnt_reg + BYTE_CNT_W'(1);
                if (issue_cnt_reg == BYTE_CNT_W'(PIXELS_PER_WORD - 1))
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!rd_pend_reg && out_free)
                begin
                    out_valid_next   = 1'b1;
                    word_low_next    = shift_reg[HALF_W-1:0];
                    word_high_next   = shift_reg[WORD_W-1:HALF_W];
                    frame_start_next = 1'b0;
                    packet_last_next = (word_cnt_reg == WORD_CNT_W'(WORDS_PER_ROW - 1));
                    if (word_cnt_reg == WORD_CNT_W'(WORDS_PER_ROW - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        word_cnt_next = word_cnt_reg + WORD_CNT_W'(1);
                        state_next    = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_pend_next = rd_en;
    assign shift_next   = rd_pend_reg ? {rd_data, shift_reg[WORD_W-1:PIXEL_W]} : shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            rd_addr_reg   <= '0;
            issue_cnt_reg <= '0;
            word_cnt_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            rd_addr_reg   <= rd_addr_next;
            issue_cnt_reg <= issue_cnt_next;
            word_cnt_reg  <= word_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg       <= shift_next;
        word_low_reg    <= word_low_next;
        word_high_reg   <= word_high_next;
        frame_start_reg <= frame_start_next;
        packet_last_reg <= packet_last_next;
    end

    assign word_valid  = out_valid_reg;
    assign word_low    = word_low_reg;
    assign word_high   = word_high_reg;
    assign frame_start = frame_start_reg;
    assign packet_last = packet_last_reg;

endmodule
